// ===== sv/wlra_pkg.sv =====
// Package for the wrapping log ring allocator.
// Holds the store geometry, the item types and the opcode codes.
// Depends on nothing; every other file imports it.
`default_nettype none

package wlra_pkg;

	localparam int STORE_BYTES = 4096;
	localparam int ALIGN_BYTES = 8;

	localparam int FIELD_W  = 13;
	localparam int OFFSET_W = 12;
	localparam int OFS_W    = $clog2(STORE_BYTES + 1);
	localparam int NEED_W   = FIELD_W + 1;
	localparam int CMP_W    = ((NEED_W > OFS_W) ? NEED_W : OFS_W) + 1;

	localparam bit ALIGN_POW2 = (ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0;
	localparam int RECIP_SH   = NEED_W + 7;
	localparam int RECIP_W    = RECIP_SH + 1;
	localparam longint RECIP  = ((64'd1 << RECIP_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_CLEAR   = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t              opcode;
		logic [FIELD_W-1:0]   alloc_length;
		logic [FIELD_W-1:0]   position;
	} req_t;

	typedef struct packed {
		logic                 ok;
		logic [OFFSET_W-1:0]  offset;
	} rsp_t;

endpackage

`default_nettype wire

// ===== sv/wlra_round.sv =====
// Rounds a requested length up to a multiple of the alignment.
// Uses a mask for a power-of-two alignment and a reciprocal multiply otherwise.
// Depends on wlra_pkg.
`default_nettype none

module wlra_round (
	input  wire logic [wlra_pkg::FIELD_W-1:0] want,
	output logic      [wlra_pkg::NEED_W-1:0]  need
);
	import wlra_pkg::*;

	logic [NEED_W-1:0] sum;

	assign sum = NEED_W'(want) + NEED_W'(ALIGN_BYTES - 1);

	if (ALIGN_POW2) begin : g_mask
		assign need = sum & ~NEED_W'(ALIGN_BYTES - 1);
	end else begin : g_recip
		localparam int PW = NEED_W + RECIP_W;
		logic [PW-1:0]     prod;
		logic [NEED_W-1:0] quo;

		assign prod = PW'(sum) * PW'(RECIP);
		assign quo  = prod[RECIP_SH +: NEED_W];
		assign need = NEED_W'(quo * NEED_W'(ALIGN_BYTES));
	end

endmodule

`default_nettype wire

// ===== sv/wlra_core.sv =====
// Offset state of the allocator and the rule that updates it for one item.
// Head, tail and wrap cut change only when an item is processed.
// Depends on wlra_pkg and wlra_round.
`default_nettype none

module wlra_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire wlra_pkg::req_t req,
	output wlra_pkg::rsp_t      rsp
);
	import wlra_pkg::*;

	localparam logic [OFS_W-1:0] SB_O = OFS_W'(STORE_BYTES);
	localparam logic [CMP_W-1:0] SB_C = CMP_W'(STORE_BYTES);

	logic [OFS_W-1:0]  head_q, tail_q, wrap_q;
	logic [OFS_W-1:0]  head_d, tail_d, wrap_d;
	logic [NEED_W-1:0] need;
	logic [CMP_W-1:0]  h, t, wc, pos_x, pos_c, need_x, where;
	logic              ok;

	wlra_round u_round (
		.want (req.alloc_length),
		.need (need)
	);

	assign h      = CMP_W'(head_q);
	assign t      = CMP_W'(tail_q);
	assign wc     = CMP_W'(wrap_q);
	assign pos_x  = CMP_W'(req.position);
	assign pos_c  = (pos_x > SB_C) ? SB_C : pos_x;
	assign need_x = CMP_W'(need);

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		wrap_d = wrap_q;
		ok     = 1'b1;
		where  = '0;
		case (req.opcode)
			OP_ALLOC: begin
				if (h < t) begin
					if (need_x <= SB_C - t) begin
						where  = t;
						tail_d = OFS_W'(t + need_x);
					end else if (need_x < h) begin
						wrap_d = tail_q;
						tail_d = OFS_W'(need_x);
					end else begin
						ok = 1'b0;
					end
				end else if (h > t) begin
					if (need_x < h - t) begin
						where  = t;
						tail_d = OFS_W'(t + need_x);
					end else begin
						ok = 1'b0;
					end
				end else begin
					if (need_x < SB_C - t) begin
						where  = t;
						tail_d = OFS_W'(t + need_x);
					end else begin
						ok = 1'b0;
					end
				end
			end
			OP_FREE: begin
				if (pos_c == '0 && head_q != '0) begin
					tail_d = wrap_q;
					wrap_d = SB_O;
				end else begin
					tail_d = OFS_W'(pos_c);
				end
			end
			OP_RELEASE: begin
				if (h < t) begin
					if (pos_c == t) begin
						head_d = '0;
						tail_d = '0;
					end else begin
						head_d = OFS_W'(pos_c);
					end
				end else begin
					if (pos_c == wc) begin
						head_d = '0;
						wrap_d = SB_O;
					end else begin
						head_d = OFS_W'(pos_c);
					end
				end
			end
			OP_CLEAR: begin
				head_d = '0;
				tail_d = '0;
				wrap_d = SB_O;
			end
			default: begin
				head_d = '0;
				tail_d = '0;
				wrap_d = SB_O;
			end
		endcase
	end

	assign rsp.ok     = ok;
	assign rsp.offset = where[OFFSET_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			wrap_q <= SB_O;
		end else if (fire) begin
			head_q <= head_d;
			tail_q <= tail_d;
			wrap_q <= wrap_d;
		end
	end

	a_within_store: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= SB_O && tail_q <= SB_O && wrap_q <= SB_O)
		else $error("offset register beyond the store");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.opcode == OP_CLEAR |=> head_q == '0 && tail_q == '0 && wrap_q == SB_O)
		else $error("clear did not empty the store");

	a_fail_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.opcode == OP_ALLOC && !ok |=>
		$stable(tail_q) && $stable(head_q) && $stable(wrap_q))
		else $error("failed allocation changed the offsets");

	a_idle_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(tail_q) && $stable(head_q) && $stable(wrap_q))
		else $error("offsets changed without an item");

endmodule

`default_nettype wire

// ===== sv/wrapping_log_ring_allocator.sv =====
// Wrapping log ring allocator: tracks head, tail and wrap-cut offsets of a
// circular byte store and answers allocate, free, release and clear items.
// Depends on wlra_pkg and wlra_core.
//
// The request channel carries one item of type req_t: an opcode, a length
// for allocation and a position for free and release. The response channel
// returns exactly one rsp_t per request: ok, and the offset of an allocated
// record (zero for a failed allocation and for the other opcodes).
// Each request is registered in the input register, processed against the
// offset registers by the core and its response registered in the output
// register, from which it is offered until it is accepted.
// One request is accepted in every cycle while responses are taken; the
// three offset registers are updated once for each processed request.
// Reset empties the store: head and tail at zero, wrap cut at the store size.
// While the response side stalls, the held response stays on the port, one
// further request waits in the input register and req_stall is raised.
`default_nettype none

module wrapping_log_ring_allocator (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire wlra_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output wlra_pkg::rsp_t      rsp
);
	import wlra_pkg::*;

	logic valid_s1, valid_s2, advance, fire;
	req_t req_s1;
	rsp_t rsp_s2, rsp_c;

	assign advance   = !valid_s2 || !rsp_stall;
	assign fire      = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	wlra_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.rsp    (rsp_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_s2 <= rsp_c;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

`default_nettype wire
